### rtl/mcsg_pkg.sv
// shared types, constants and the microcode table of the circle span generator
`default_nettype none

package mcsg_pkg;

  // defaults for the top level parameters
  localparam int MAX_RADIUS_DEF = 80;
  localparam int COORD_BITS_DEF = 11;

  // fixed field widths
  localparam int RADIUS_W = 7;
  localparam int WIDTH_W  = 8;

  // microcode address width and step names
  localparam int UC_AW = 1;
  localparam logic [UC_AW-1:0] STEP_FETCH = 1'b0;
  localparam logic [UC_AW-1:0] STEP_SPAN  = 1'b1;

  // what a step waits for before it completes
  typedef enum logic {
    WAIT_IN,
    WAIT_SLOT
  } wait_t;

  // branch condition tested when a step completes
  typedef enum logic {
    BR_NEVER,
    BR_MORE
  } br_t;

  typedef struct packed {
    logic             take_in;
    logic             emit;
    wait_t            wait_on;
    br_t              br;
    logic [UC_AW-1:0] nxt_hit;
    logic [UC_AW-1:0] nxt_miss;
  } uc_word_t;

  // sequencer to datapath
  typedef struct packed {
    logic load;
    logic fire;
  } dp_ctl_t;

  // datapath to sequencer
  typedef struct packed {
    logic slot_free;
    logic more;
  } dp_sts_t;

  // control store
  function automatic uc_word_t uc_rom(input logic [UC_AW-1:0] addr);
    uc_word_t w;
    case (addr)
      STEP_FETCH: begin
        w = '{take_in: 1'b1, emit: 1'b0, wait_on: WAIT_IN, br: BR_NEVER,
              nxt_hit: STEP_FETCH, nxt_miss: STEP_SPAN};
      end
      STEP_SPAN: begin
        w = '{take_in: 1'b0, emit: 1'b1, wait_on: WAIT_SLOT, br: BR_MORE,
              nxt_hit: STEP_SPAN, nxt_miss: STEP_FETCH};
      end
      default: begin
        w = '{take_in: 1'b1, emit: 1'b0, wait_on: WAIT_IN, br: BR_NEVER,
              nxt_hit: STEP_FETCH, nxt_miss: STEP_SPAN};
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/mcsg_ifs.sv
// valid/ready channel interfaces for circles in and span sets out
`default_nettype none

interface mcsg_in_if
  import mcsg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] center_x;
  logic [COORD_BITS-1:0] center_y;
  logic [RADIUS_W-1:0]   radius;

  modport source (output valid, output center_x, output center_y, output radius,
                  input ready);
  modport sink   (input valid, input center_x, input center_y, input radius,
                  output ready);
endinterface

interface mcsg_out_if
  import mcsg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic signed [COORD_BITS:0] outer_left;
  logic [WIDTH_W-1:0]         outer_width;
  logic [COORD_BITS:0]        outer_row_below;
  logic signed [COORD_BITS:0] outer_row_above;
  logic signed [COORD_BITS:0] inner_left;
  logic [WIDTH_W-1:0]         inner_width;
  logic [COORD_BITS:0]        inner_row_below;
  logic signed [COORD_BITS:0] inner_row_above;
  logic                       last_step;

  modport source (output valid, output outer_left, output outer_width,
                  output outer_row_below, output outer_row_above,
                  output inner_left, output inner_width,
                  output inner_row_below, output inner_row_above,
                  output last_step, input ready);
  modport sink   (input valid, input outer_left, input outer_width,
                  input outer_row_below, input outer_row_above,
                  input inner_left, input inner_width,
                  input inner_row_below, input inner_row_above,
                  input last_step, output ready);
endinterface

`default_nettype wire

### rtl/mcsg_useq.sv
// microcode sequencer: step counter, control store lookup and branching
`default_nettype none

module mcsg_useq
  import mcsg_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_ctl_t ctl
);

  logic [UC_AW-1:0] step_r;
  logic [UC_AW-1:0] step_nxt;
  uc_word_t         word;
  logic             go;
  logic             taken;

  assign word = uc_rom(step_r);

  always_comb begin
    case (word.wait_on)
      WAIT_IN:   go = in_valid;
      WAIT_SLOT: go = sts.slot_free;
      default:   go = 1'b0;
    endcase
    case (word.br)
      BR_NEVER: taken = 1'b0;
      BR_MORE:  taken = sts.more;
      default:  taken = 1'b0;
    endcase
    if (!go) begin
      step_nxt = step_r;
    end else if (taken) begin
      step_nxt = word.nxt_hit;
    end else begin
      step_nxt = word.nxt_miss;
    end
  end

  assign in_ready = word.take_in;
  assign ctl      = '{load: word.take_in & in_valid, fire: word.emit & sts.slot_free};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_FETCH;
    end else begin
      step_r <= step_nxt;
    end
  end

`ifndef SYNTHESIS
  a_load_to_span: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |=> step_r == STEP_SPAN)
    else $error("circle load did not move to the span step");
  a_last_to_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fire && !sts.more |=> step_r == STEP_FETCH)
    else $error("final span did not return to fetch");
  a_load_xor_fire: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.load && ctl.fire))
    else $error("load and emit in the same cycle");
`endif

endmodule

`default_nettype wire

### rtl/mcsg_dpath.sv
// datapath: octant recurrence registers, span arithmetic and output register
`default_nettype none

module mcsg_dpath
  import mcsg_pkg::*;
#(
  parameter int MAX_RADIUS = MAX_RADIUS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_ctl_t               ctl,
  output dp_sts_t               sts,
  input  logic [COORD_BITS-1:0] in_center_x,
  input  logic [COORD_BITS-1:0] in_center_y,
  input  logic [RADIUS_W-1:0]   in_radius,
  mcsg_out_if.source            out_chan
);

  localparam int RAD_BITS = $clog2(MAX_RADIUS + 1);
  localparam int OCT_W    = RAD_BITS + 1;
  localparam int ERR_W    = RAD_BITS + 3;
  localparam int POS_W    = COORD_BITS + 1;
  localparam int CMP_W    = (RAD_BITS > RADIUS_W) ? RAD_BITS : RADIUS_W;

  logic [COORD_BITS-1:0]   cx_r;
  logic [COORD_BITS-1:0]   cy_r;
  logic signed [OCT_W-1:0] x_r;
  logic signed [OCT_W-1:0] y_r;
  logic signed [ERR_W-1:0] err_r;

  logic [CMP_W-1:0]        r_ext;
  logic [CMP_W-1:0]        r_sat;
  logic signed [OCT_W-1:0] r_oct;
  logic signed [OCT_W-1:0] x_nxt;
  logic signed [OCT_W-1:0] y_nxt;
  logic signed [ERR_W-1:0] err_nxt;
  logic signed [ERR_W-1:0] y1_e;
  logic signed [ERR_W-1:0] x1_e;
  logic signed [POS_W-1:0] cx_e;
  logic signed [POS_W-1:0] cy_e;
  logic signed [POS_W-1:0] x_e;
  logic signed [POS_W-1:0] y_e;

  logic                    out_valid_r;
  logic signed [POS_W-1:0] outer_left_r;
  logic [WIDTH_W-1:0]      outer_width_r;
  logic [POS_W-1:0]        outer_row_below_r;
  logic signed [POS_W-1:0] outer_row_above_r;
  logic signed [POS_W-1:0] inner_left_r;
  logic [WIDTH_W-1:0]      inner_width_r;
  logic [POS_W-1:0]        inner_row_below_r;
  logic signed [POS_W-1:0] inner_row_above_r;
  logic                    last_r;

  // radius saturation
  assign r_ext = CMP_W'(in_radius);
  assign r_sat = (r_ext > CMP_W'(MAX_RADIUS)) ? CMP_W'(MAX_RADIUS) : r_ext;
  assign r_oct = signed'(OCT_W'(r_sat));

  // one step of the recurrence
  always_comb begin
    y_nxt = y_r + OCT_W'(1);
    if (err_r[ERR_W-1]) begin
      x_nxt = x_r;
    end else begin
      x_nxt = x_r - OCT_W'(1);
    end
    y1_e = ERR_W'(y_nxt);
    x1_e = ERR_W'(x_nxt);
    if (err_r[ERR_W-1]) begin
      err_nxt = err_r + (y1_e <<< 1) + ERR_W'(1);
    end else begin
      err_nxt = err_r + ((y1_e - x1_e + ERR_W'(1)) <<< 1);
    end
  end

  assign cx_e = signed'({1'b0, cx_r});
  assign cy_e = signed'({1'b0, cy_r});
  assign x_e  = POS_W'(x_r);
  assign y_e  = POS_W'(y_r);

  assign sts = '{slot_free: !out_valid_r || out_chan.ready, more: (x_nxt >= y_nxt)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      x_r   <= '0;
      y_r   <= '0;
      err_r <= '0;
    end else if (ctl.load) begin
      cx_r  <= in_center_x;
      cy_r  <= in_center_y;
      x_r   <= r_oct;
      y_r   <= '0;
      err_r <= ERR_W'(1) - ERR_W'(r_oct);
    end else if (ctl.fire) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      err_r <= err_nxt;
    end
    if (ctl.fire) begin
      outer_left_r      <= cx_e - x_e;
      outer_width_r     <= WIDTH_W'({x_r[RAD_BITS-1:0], 1'b0});
      outer_row_below_r <= cy_e + y_e;
      outer_row_above_r <= cy_e - y_e;
      inner_left_r      <= cx_e - y_e;
      inner_width_r     <= WIDTH_W'({y_r[RAD_BITS-1:0], 1'b0});
      inner_row_below_r <= cy_e + x_e;
      inner_row_above_r <= cy_e - x_e;
      last_r            <= !(x_nxt >= y_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.outer_left      = outer_left_r;
  assign out_chan.outer_width     = outer_width_r;
  assign out_chan.outer_row_below = outer_row_below_r;
  assign out_chan.outer_row_above = outer_row_above_r;
  assign out_chan.inner_left      = inner_left_r;
  assign out_chan.inner_width     = inner_width_r;
  assign out_chan.inner_row_below = inner_row_below_r;
  assign out_chan.inner_row_above = inner_row_above_r;
  assign out_chan.last_step       = last_r;

`ifndef SYNTHESIS
  a_octant_order: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fire |-> x_r >= y_r)
    else $error("span emitted outside the octant");
  a_load_init: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |=> (y_r == '0) && (err_r == ERR_W'(1) - ERR_W'(x_r)))
    else $error("recurrence not initialised on load");
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fire && !sts.more |=> out_valid_r && last_r)
    else $error("final span not marked");
`endif

endmodule

`default_nettype wire

### rtl/midpoint_circle_span_generator.sv
// top level of the midpoint circle span generator
`default_nettype none

// Accepts one circle per beat (center and radius, radius saturated to MAX_RADIUS)
// and produces one span-set beat per midpoint iteration, y = 0, 1, ... while
// x >= y, the final beat carrying last_step. Each beat holds the two wide spans
// (left edge center_x - x, width 2x, rows center_y +/- y) and the two narrow
// spans (left edge center_x - y, width 2y, rows center_y +/- x); left edges and
// upper rows are two's complement and may go negative. A circle is loaded in
// the fetch step, then one span beat is produced per cycle while the output is
// drained; a circle of radius r gives N beats, N being its iteration count
// (about r/sqrt(2) + 1; 57 iterations at radius 80). The span microword
// performs one recurrence step and one output register load per cycle while
// the output register has room. A new circle is taken while the final beat
// of the previous one still waits in the output register.
module midpoint_circle_span_generator
  import mcsg_pkg::*;
#(
  parameter int MAX_RADIUS = MAX_RADIUS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
)
(
  input  logic        clk,
  input  logic        rst_n,
  mcsg_in_if.sink     in_chan,
  mcsg_out_if.source  out_chan
);

  // control word decoded by the sequencer towards the datapath
  dp_ctl_t ctl;
  // slot and loop status back from the datapath
  dp_sts_t sts;
  logic    in_ready;

  // the step counter walks a two-word program: fetch a circle, then loop on
  // the span word until the recurrence leaves the octant
  mcsg_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // ready comes straight from the fetch microword
  assign in_chan.ready = in_ready;

  // octant registers, span adders and the output register
  mcsg_dpath #(
    .MAX_RADIUS (MAX_RADIUS),
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .sts         (sts),
    .in_center_x (in_chan.center_x),
    .in_center_y (in_chan.center_y),
    .in_radius   (in_chan.radius),
    .out_chan    (out_chan)
  );

endmodule

`default_nettype wire
